>>> hdl/tprl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tprl_pkg;

  localparam int CHANNELS       = 8;
  localparam int CHAN_BITS      = 3;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 24;
  localparam int COEF_FRAC_BITS = 20;

  localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS   = PROD_BITS + 2;
  localparam int SHIFT_BITS = ACC_BITS - COEF_FRAC_BITS;

  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 4;
  localparam int REG_IDX_BITS  = CFG_ADDR_BITS - 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic [CHAN_BITS-1:0]          chan_t;
  typedef logic [REG_IDX_BITS-1:0]       reg_idx_t;

  typedef enum logic {
    OP_FILTER = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  // history word of one channel
  typedef struct packed {
    sample_t y2;
    sample_t y1;
  } hist_t;

  // history write port
  typedef struct packed {
    logic  en;
    chan_t ch;
    hist_t data;
  } hist_wr_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
  } coefs_t;

  localparam reg_idx_t REG_COEF_A = REG_IDX_BITS'(0);
  localparam reg_idx_t REG_COEF_B = REG_IDX_BITS'(1);
  localparam reg_idx_t REG_COEF_C = REG_IDX_BITS'(2);

  localparam coef_t COEF_A_RESET = '0;
  localparam coef_t COEF_B_RESET = '0;
  localparam coef_t COEF_C_RESET = coef_t'(1 << COEF_FRAC_BITS);

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic signed [ACC_BITS-1:0] ACC_ROUND =
    ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

  function automatic logic chan_ok(chan_t ch);
    return {1'b0, ch} < (CHAN_BITS+1)'(CHANNELS);
  endfunction

endpackage

`default_nettype wire

>>> hdl/two_pole_resonant_lowpass_unit.sv
// Input to output beat: read, multiply, sum/saturate, each a registered step.
// Throughput: one beat per cycle for interleaved channels while out_ready holds;
//   a beat directly behind one of its own channel waits for that history write.
// That wait comes from the y -> y1 recurrence spanning the multiply and sum stages.
// Reset (rst_n, synchronous): coefficients go to A=0, B=0, C=1.0, every
//   channel's history reads as zero, pipeline empties; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module two_pole_resonant_lowpass_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input beats
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_opcode,
  input  wire logic [tprl_pkg::CHAN_BITS-1:0]      in_channel,
  input  wire logic signed [tprl_pkg::SAMPLE_BITS-1:0] in_sample_in,
  // result beats
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [tprl_pkg::SAMPLE_BITS-1:0]  out_sample_out,
  output logic [tprl_pkg::CHAN_BITS-1:0]           out_channel,
  output logic                                     out_saturated,
  // APB register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [tprl_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire logic [tprl_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic      [tprl_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                     pready
);

  tprl_pkg::coefs_t   coefs;
  tprl_pkg::hist_t    rd_hist;
  tprl_pkg::hist_wr_t hist_wr;
  tprl_pkg::sample_t  mac_y;
  logic               mac_sat;

  // Stage 1: history read data arrives, products are formed
  logic               s1_valid_r, s1_valid_nxt;
  tprl_pkg::op_t      s1_op_r;
  tprl_pkg::chan_t    s1_ch_r;
  tprl_pkg::sample_t  s1_x_r;

  // Stage 2: sum, round, saturate, write history back
  logic               s2_valid_r, s2_valid_nxt;
  tprl_pkg::op_t      s2_op_r;
  tprl_pkg::chan_t    s2_ch_r;
  logic               s2_ok_r;
  tprl_pkg::sample_t  s2_y1_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  tprl_pkg::sample_t  out_sample_r;
  tprl_pkg::chan_t    out_ch_r;
  logic               out_sat_r;

  logic in_fire, s1_move, s2_move, out_move, s2_open, hazard, s2_filter;

  tprl_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  // ---------------------------------------------------------------------------
  // Flow control. Each stage moves when the one after it is empty or moving.
  // The y -> y1 recurrence cannot close on back-to-back beats, so a beat in stage 1
  // holds while stage 2 still owes a write to the same channel; the memory
  // refreshes the held word when that write lands.
  // ---------------------------------------------------------------------------
  assign out_move = !out_valid_r || out_ready;
  assign s2_move  = s2_valid_r && out_move;
  assign s2_open  = !s2_valid_r || out_move;
  assign hazard   = s1_valid_r && s2_valid_r && s2_ok_r && (s2_ch_r == s1_ch_r);
  assign s1_move  = s1_valid_r && s2_open && !hazard;
  assign in_ready = !s1_valid_r || s1_move;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s1_move) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_move) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // History memory: read on accept, write back as stage 2 retires.
  // A clear writes zero history; an out-of-range channel leaves memory alone.
  // ---------------------------------------------------------------------------
  assign s2_filter = (s2_op_r == tprl_pkg::OP_FILTER) && s2_ok_r;

  always_comb begin
    hist_wr.en      = s2_move && s2_ok_r;
    hist_wr.ch      = s2_ch_r;
    hist_wr.data.y2 = s2_filter ? s2_y1_r : '0;
    hist_wr.data.y1 = s2_filter ? mac_y   : '0;
  end

  tprl_hist_mem u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_ch   (in_channel),
    .hold_ch (s1_ch_r),
    .wr      (hist_wr),
    .rd_hist (rd_hist)
  );

  tprl_mac u_mac (
    .clk   (clk),
    .en    (s1_move),
    .hist  (rd_hist),
    .x     (s1_x_r),
    .coefs (coefs),
    .y     (mac_y),
    .sat   (mac_sat)
  );

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r <= tprl_pkg::op_t'(in_opcode);
      s1_ch_r <= in_channel;
      s1_x_r  <= in_sample_in;
    end
    if (s1_move) begin
      s2_op_r <= s1_op_r;
      s2_ch_r <= s1_ch_r;
      s2_ok_r <= tprl_pkg::chan_ok(s1_ch_r);
      s2_y1_r <= rd_hist.y1;
    end
    if (s2_move) begin
      out_sample_r <= s2_filter ? mac_y : '0;
      out_sat_r    <= s2_filter && mac_sat;
      out_ch_r     <= s2_ch_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_channel    = out_ch_r;
  assign out_saturated  = out_sat_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // history must be current when products are taken
  a_no_stale_read: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && hist_wr.en) |-> (hist_wr.ch != s1_ch_r))
    else $error("stage 1 moved past a pending write to its channel");

  // the same-channel wait lasts no longer than the write it waits for
  a_hazard_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (hazard && out_move) |=> !hazard)
    else $error("same-channel hold did not release");

  // clipped results sit at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      ((out_sample_r == tprl_pkg::SAMPLE_MAX) || (out_sample_r == tprl_pkg::SAMPLE_MIN)))
    else $error("saturated flag without rail value");

  // an accepted beat always lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted beat lost");

endmodule

`default_nettype wire

>>> hdl/tprl_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module tprl_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [tprl_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  wire logic [tprl_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic      [tprl_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                      pready,
  output tprl_pkg::coefs_t                          coefs
);

  localparam int EXT_BITS = tprl_pkg::CFG_DATA_BITS - tprl_pkg::COEF_BITS;

  tprl_pkg::coefs_t   coefs_r, coefs_nxt;
  tprl_pkg::reg_idx_t reg_idx;
  tprl_pkg::coef_t    wdata;
  tprl_pkg::coef_t    rd_coef;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[tprl_pkg::CFG_ADDR_BITS-1:2];
  assign wdata   = tprl_pkg::coef_t'(pwdata[tprl_pkg::COEF_BITS-1:0]);
  assign wr_en   = psel && penable && pwrite;
  assign coefs   = coefs_r;

  always_comb begin
    coefs_nxt = coefs_r;
    if (wr_en) begin
      case (reg_idx)
        tprl_pkg::REG_COEF_A: coefs_nxt.a = wdata;
        tprl_pkg::REG_COEF_B: coefs_nxt.b = wdata;
        tprl_pkg::REG_COEF_C: coefs_nxt.c = wdata;
        default: ;  // unmapped: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coefs_r.a <= tprl_pkg::COEF_A_RESET;
      coefs_r.b <= tprl_pkg::COEF_B_RESET;
      coefs_r.c <= tprl_pkg::COEF_C_RESET;
    end else begin
      coefs_r <= coefs_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      tprl_pkg::REG_COEF_A: rd_coef = coefs_r.a;
      tprl_pkg::REG_COEF_B: rd_coef = coefs_r.b;
      tprl_pkg::REG_COEF_C: rd_coef = coefs_r.c;
      default:              rd_coef = '0;
    endcase
  end

  assign prdata = {{EXT_BITS{rd_coef[tprl_pkg::COEF_BITS-1]}}, rd_coef};

endmodule

`default_nettype wire

>>> hdl/tprl_hist_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module tprl_hist_mem (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,     // new beat enters the read stage
  input  wire tprl_pkg::chan_t   rd_ch,
  input  wire tprl_pkg::chan_t   hold_ch,   // channel of the beat sitting in read stage
  input  wire tprl_pkg::hist_wr_t wr,
  output tprl_pkg::hist_t        rd_hist
);

  tprl_pkg::hist_t                   mem [tprl_pkg::CHANNELS];
  logic [tprl_pkg::CHANNELS-1:0]     valid_r, valid_nxt;
  tprl_pkg::hist_t                   hist_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.ch] <= wr.data;
    end
  end

  // entry never written reads as zero history
  always_comb begin
    valid_nxt = valid_r;
    if (wr.en) begin
      valid_nxt[wr.ch] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // read port; a write landing on the same entry is bypassed, and a write
  // to the held beat's channel refreshes the held word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.ch == rd_ch)) begin
        hist_r <= wr.data;
      end else if (valid_r[rd_ch]) begin
        hist_r <= mem[rd_ch];
      end else begin
        hist_r <= '0;
      end
    end else if (wr.en && (wr.ch == hold_ch)) begin
      hist_r <= wr.data;
    end
  end

  assign rd_hist = hist_r;

endmodule

`default_nettype wire

>>> hdl/tprl_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module tprl_mac (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire tprl_pkg::hist_t   hist,
  input  wire tprl_pkg::sample_t x,
  input  wire tprl_pkg::coefs_t  coefs,
  output tprl_pkg::sample_t      y,
  output logic                   sat
);

  localparam int PB = tprl_pkg::PROD_BITS;
  localparam int AB = tprl_pkg::ACC_BITS;
  localparam int SB = tprl_pkg::SHIFT_BITS;
  localparam int YB = tprl_pkg::SAMPLE_BITS;

  logic signed [PB-1:0] pa_r, pb_r, pc_r;
  logic signed [AB-1:0] acc;
  logic signed [SB-1:0] shifted;
  logic [SB-YB:0]       top;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= PB'($signed(hist.y1) * $signed(coefs.a));
      pb_r <= PB'($signed(hist.y2) * $signed(coefs.b));
      pc_r <= PB'($signed(x) * $signed(coefs.c));
    end
  end

  // round half up, then floor shift
  assign acc = AB'(pa_r) - AB'(pb_r) + AB'(pc_r) + tprl_pkg::ACC_ROUND;
  assign shifted = acc[AB-1:tprl_pkg::COEF_FRAC_BITS];
  assign top = shifted[SB-1:YB-1];
  assign sat = !((&top) || !(|top));

  always_comb begin
    if (sat) begin
      y = shifted[SB-1] ? tprl_pkg::SAMPLE_MIN : tprl_pkg::SAMPLE_MAX;
    end else begin
      y = tprl_pkg::sample_t'(shifted[YB-1:0]);
    end
  end

endmodule

`default_nettype wire
